// ===== src/i2cee_pkg.sv =====
// i2cee_pkg: types, codes and helper functions shared by the eeprom sequencer
// used by i2cee_front, i2cee_queue, i2cee_back and i2c_eeprom_page_access_sequencer_top
// no dependencies
package i2cee_pkg;

  // eeprom byte address width (7..16)
  localparam int unsigned AddrWidth = 16;

  localparam int unsigned MaxCmds = 5;
  localparam int unsigned CntWidth = $clog2(MaxCmds + 1);
  localparam int unsigned IdxWidth = $clog2(MaxCmds);

  localparam logic [7:0] CtrlWrite = 8'hA0;
  localparam logic [7:0] CtrlRead = 8'hA1;
  localparam logic [7:0] AckStatus = 8'h18;
  localparam logic [7:0] StatusMask = 8'b11111000;
  localparam logic [2:0] MinPageLog2 = 3'd3;

  // configuration register indexes
  localparam logic [1:0] RegPageLog2 = 2'd0;
  localparam logic [1:0] RegWideAddr = 2'd1;
  localparam logic [1:0] RegDevPins = 2'd2;

  typedef enum logic [1:0] {
    OpBeginWr = 2'd0,
    OpData    = 2'd1,
    OpBeginRd = 2'd2,
    OpReply   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CmdStart    = 4'd0,
    CmdSend     = 4'd1,
    CmdRecvAck  = 4'd2,
    CmdRecvNack = 4'd3,
    CmdStop     = 4'd4,
    CmdWait     = 4'd5,
    CmdData     = 4'd6,
    CmdNoack    = 4'd7,
    CmdReject   = 4'd8
  } cmd_e;

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhWrAck  = 5'b00010,
    PhWrData = 5'b00100,
    PhRdAck  = 5'b01000,
    PhRdData = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [2:0] page_log2;
    logic       wide;
    logic [2:0] pins;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] start_address;
    logic [16:0] byte_count;
    logic [7:0]  write_data;
    logic [7:0]  bus_status;
    logic [7:0]  bus_read_data;
  } item_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } ent_t;

  // one item's worth of bus commands, entry 0 goes out first
  typedef struct packed {
    logic [CntWidth-1:0]  cnt;
    ent_t [MaxCmds-1:0]   ent;
  } desc_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } q_head_t;

  function automatic ent_t mk_ent(cmd_e cmd, logic [7:0] data);
    ent_t e;
    e.cmd  = cmd;
    e.data = data;
    return e;
  endfunction

  // control byte: base with chip select bits, narrow parts add address bits 10..8
  function automatic logic [7:0] ctrl_byte(logic [7:0] base, cfg_t cfg, logic [15:0] addr);
    logic [2:0] sel;
    sel = cfg.wide ? cfg.pins : (cfg.pins | addr[10:8]);
    return base | {4'b0000, sel, 1'b0};
  endfunction

endpackage

// ===== src/i2cee_front.sv =====
// i2cee_front: accepts host items, tracks the transfer phase and builds the command list
// depends on i2cee_pkg
module i2cee_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cee_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cee_pkg::item_t    item_i,
  input  logic                q_full_i,
  output logic                push_o,
  output i2cee_pkg::desc_t    desc_o
);

  i2cee_pkg::phase_e                    phase_q, phase_d;
  logic [i2cee_pkg::AddrWidth-1:0]      cur_q, cur_d;
  logic [16:0]                          bytes_q, bytes_d;
  logic [7:0]                           chunk_q, chunk_d;

  logic [i2cee_pkg::AddrWidth-1:0]      in_addr, cur_inc;
  logic [16:0]                          bytes_dec;
  logic [7:0]                           chunk_dec;
  logic [15:0]                          ch_addr;
  logic [16:0]                          ch_bytes;
  logic [2:0]                           lg;
  logic [8:0]                           page, off, room;
  logic [7:0]                           chunk_len;
  logic                                 ack;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign in_addr   = item_i.start_address[i2cee_pkg::AddrWidth-1:0];
  assign cur_inc   = cur_q + 1'b1;
  assign bytes_dec = bytes_q - 17'd1;
  assign chunk_dec = chunk_q - 8'd1;
  assign ack       = (item_i.bus_status & i2cee_pkg::StatusMask) == i2cee_pkg::AckStatus;

  // page chunk length for a new write transaction or the next chunk of a running one
  always_comb begin
    if (item_i.op == i2cee_pkg::OpBeginWr) begin
      ch_addr  = 16'(in_addr);
      ch_bytes = item_i.byte_count;
    end else begin
      ch_addr  = 16'(cur_inc);
      ch_bytes = bytes_dec;
    end
    lg        = (cfg_i.page_log2 < i2cee_pkg::MinPageLog2) ? i2cee_pkg::MinPageLog2
                                                          : cfg_i.page_log2;
    page      = 9'd1 << lg;
    off       = {2'b00, ch_addr[6:0]} & (page - 9'd1);
    room      = page - off;
    chunk_len = (17'(room) < ch_bytes) ? room[7:0] : ch_bytes[7:0];
  end

  // phase step and command list
  always_comb begin
    phase_d     = phase_q;
    cur_d       = cur_q;
    bytes_d     = bytes_q;
    chunk_d     = chunk_q;
    desc_o      = '0;
    desc_o.cnt  = i2cee_pkg::CntWidth'(1);
    desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdReject, 8'h00);
    priority if ((item_i.op == i2cee_pkg::OpBeginWr || item_i.op == i2cee_pkg::OpBeginRd)
                 && phase_q == i2cee_pkg::PhIdle && item_i.byte_count != 17'd0) begin
      cur_d   = in_addr;
      bytes_d = item_i.byte_count;
      desc_o.cnt    = i2cee_pkg::CntWidth'(2);
      desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdStart, 8'h00);
      desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend,
                        i2cee_pkg::ctrl_byte(i2cee_pkg::CtrlWrite, cfg_i, 16'(in_addr)));
      if (item_i.op == i2cee_pkg::OpBeginWr) begin
        chunk_d = chunk_len;
        phase_d = i2cee_pkg::PhWrAck;
      end else begin
        chunk_d = 8'd0;
        phase_d = i2cee_pkg::PhRdAck;
      end
    end else if (item_i.op == i2cee_pkg::OpData && phase_q == i2cee_pkg::PhWrData) begin
      cur_d   = cur_inc;
      bytes_d = bytes_dec;
      chunk_d = chunk_dec;
      desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend, item_i.write_data);
      if (chunk_dec == 8'd0 || bytes_dec == 17'd0) begin
        desc_o.cnt    = i2cee_pkg::CntWidth'(3);
        desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdStop, 8'h00);
        desc_o.ent[2] = i2cee_pkg::mk_ent(i2cee_pkg::CmdWait, 8'h00);
        if (bytes_dec != 17'd0) begin
          // next page chunk opens right away
          desc_o.cnt    = i2cee_pkg::CntWidth'(5);
          desc_o.ent[3] = i2cee_pkg::mk_ent(i2cee_pkg::CmdStart, 8'h00);
          desc_o.ent[4] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend,
                            i2cee_pkg::ctrl_byte(i2cee_pkg::CtrlWrite, cfg_i, 16'(cur_inc)));
          chunk_d = chunk_len;
          phase_d = i2cee_pkg::PhWrAck;
        end else begin
          phase_d = i2cee_pkg::PhIdle;
        end
      end
    end else if (item_i.op == i2cee_pkg::OpReply &&
                 (phase_q == i2cee_pkg::PhWrAck || phase_q == i2cee_pkg::PhRdAck)) begin
      if (!ack) begin
        // no ack on control byte: stop, write-cycle wait on writes, error
        desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdStop, 8'h00);
        if (phase_q == i2cee_pkg::PhWrAck) begin
          desc_o.cnt    = i2cee_pkg::CntWidth'(3);
          desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdWait, 8'h00);
          desc_o.ent[2] = i2cee_pkg::mk_ent(i2cee_pkg::CmdNoack, 8'h00);
        end else begin
          desc_o.cnt    = i2cee_pkg::CntWidth'(2);
          desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdNoack, 8'h00);
        end
        phase_d = i2cee_pkg::PhIdle;
      end else if (phase_q == i2cee_pkg::PhWrAck) begin
        if (cfg_i.wide) begin
          desc_o.cnt    = i2cee_pkg::CntWidth'(2);
          desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend, 8'(16'(cur_q) >> 8));
          desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend, 8'(16'(cur_q)));
        end else begin
          desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend, 8'(16'(cur_q)));
        end
        phase_d = i2cee_pkg::PhWrData;
      end else begin
        // read: address, repeated start, read control, first receive
        if (cfg_i.wide) begin
          desc_o.cnt    = i2cee_pkg::CntWidth'(5);
          desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend, 8'(16'(cur_q) >> 8));
          desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend, 8'(16'(cur_q)));
          desc_o.ent[2] = i2cee_pkg::mk_ent(i2cee_pkg::CmdStart, 8'h00);
          desc_o.ent[3] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend,
                            i2cee_pkg::ctrl_byte(i2cee_pkg::CtrlRead, cfg_i, 16'(cur_q)));
          desc_o.ent[4] = i2cee_pkg::mk_ent((bytes_q == 17'd1) ? i2cee_pkg::CmdRecvNack
                                                              : i2cee_pkg::CmdRecvAck, 8'h00);
        end else begin
          desc_o.cnt    = i2cee_pkg::CntWidth'(4);
          desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend, 8'(16'(cur_q)));
          desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdStart, 8'h00);
          desc_o.ent[2] = i2cee_pkg::mk_ent(i2cee_pkg::CmdSend,
                            i2cee_pkg::ctrl_byte(i2cee_pkg::CtrlRead, cfg_i, 16'(cur_q)));
          desc_o.ent[3] = i2cee_pkg::mk_ent((bytes_q == 17'd1) ? i2cee_pkg::CmdRecvNack
                                                              : i2cee_pkg::CmdRecvAck, 8'h00);
        end
        phase_d = i2cee_pkg::PhRdData;
      end
    end else if (item_i.op == i2cee_pkg::OpReply && phase_q == i2cee_pkg::PhRdData) begin
      cur_d   = cur_inc;
      bytes_d = bytes_dec;
      desc_o.cnt    = i2cee_pkg::CntWidth'(2);
      desc_o.ent[0] = i2cee_pkg::mk_ent(i2cee_pkg::CmdData, item_i.bus_read_data);
      if (bytes_dec != 17'd0) begin
        desc_o.ent[1] = i2cee_pkg::mk_ent((bytes_dec == 17'd1) ? i2cee_pkg::CmdRecvNack
                                                              : i2cee_pkg::CmdRecvAck, 8'h00);
      end else begin
        desc_o.ent[1] = i2cee_pkg::mk_ent(i2cee_pkg::CmdStop, 8'h00);
        phase_d = i2cee_pkg::PhIdle;
      end
    end else begin
      // wrong phase or zero count: single reject, state untouched
      phase_d = phase_q;
    end
  end

  // transfer state, updated on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cee_pkg::PhIdle;
      cur_q   <= '0;
      bytes_q <= '0;
      chunk_q <= '0;
    end else if (push_o) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      bytes_q <= bytes_d;
      chunk_q <= chunk_d;
    end
  end

endmodule

// ===== src/i2cee_queue.sv =====
// i2cee_queue: two-entry queue of command lists between front and back end
// depends on i2cee_pkg
module i2cee_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  i2cee_pkg::desc_t     desc_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output i2cee_pkg::q_head_t   head_o
);

  i2cee_pkg::desc_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       fill_q;

  assign full_o       = fill_q == 2'd2;
  assign head_o.valid = fill_q != 2'd0;
  assign head_o.desc  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

// ===== src/i2cee_back.sv =====
// i2cee_back: walks the queued command list and drives one command per cycle while the output is not stalled
// depends on i2cee_pkg
module i2cee_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2cee_pkg::q_head_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cee_pkg::cmd_e     out_cmd_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);

  logic [i2cee_pkg::IdxWidth-1:0] idx_q;
  logic                           valid_q;
  i2cee_pkg::cmd_e                cmd_q;
  logic [7:0]                     byte_q;
  logic                           last_q;
  logic                           load, is_last;
  i2cee_pkg::ent_t                cur_ent;

  assign load    = head_i.valid && (!valid_q || out_ready_i);
  assign cur_ent = head_i.desc.ent[idx_q];
  assign is_last = i2cee_pkg::CntWidth'(idx_q) == head_i.desc.cnt - 1'b1;
  assign pop_o   = load && is_last;

  assign out_valid_o = valid_q;
  assign out_cmd_o   = cmd_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  // entry index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= is_last ? '0 : idx_q + 1'b1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= cur_ent.cmd;
      byte_q <= cur_ent.data;
      last_q <= is_last;
    end
  end

endmodule

// ===== src/i2c_eeprom_page_access_sequencer_top.sv =====
// i2c_eeprom_page_access_sequencer_top: serial eeprom page access sequencer
// depends on i2cee_pkg, i2cee_front, i2cee_queue, i2cee_back
//
// Usage:
//  s_axis carries host transactions: tuser is the op (begin write, data byte,
//  begin read, bus reply), tdata the address, count and byte fields.
//  m_axis carries bus commands (tuser) with their byte (tdata); tlast marks
//  the final command caused by one input transaction.
//  The APB port sets page size, wide addressing and chip select pins; write
//  it only while the block is idle.
//  With the back end free, the first command of a transaction passes the
//  command queue and the back end's output register before it is valid.
//  Each transaction yields 1 to 5 commands, sent at one command per cycle
//  while the receiver keeps m_axis_tready high.
//  The front end keeps accepting while the two-entry command queue has room.
//  A stalled receiver holds the output register; once the queue fills,
//  s_axis_tready drops.
//  Reset clears the phase, address and counters to idle and zero, empties
//  the queue and loads the register defaults (page 16 bytes, narrow, pins 0).
module i2c_eeprom_page_access_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_address[15:0], byte_count[32:16], write_data[40:33],
  // bus_status[48:41], bus_read_data[56:49], zero[63:57]
  input  logic [63:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // stream output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cmd_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  // cmd[3:0]
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cee_pkg::cfg_t    cfg_q;
  i2cee_pkg::item_t   item;
  i2cee_pkg::desc_t   desc;
  i2cee_pkg::q_head_t head;
  i2cee_pkg::cmd_e    out_cmd;
  logic               push, pop, q_full;
  logic               cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_log2 <= 3'd4;
      cfg_q.wide      <= 1'b0;
      cfg_q.pins      <= 3'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        i2cee_pkg::RegPageLog2: cfg_q.page_log2 <= pwdata[2:0];
        i2cee_pkg::RegWideAddr: cfg_q.wide      <= pwdata[0];
        i2cee_pkg::RegDevPins:  cfg_q.pins      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      i2cee_pkg::RegPageLog2: prdata = {29'd0, cfg_q.page_log2};
      i2cee_pkg::RegWideAddr: prdata = {31'd0, cfg_q.wide};
      i2cee_pkg::RegDevPins:  prdata = {29'd0, cfg_q.pins};
      default:                prdata = 32'd0;
    endcase
  end

  // input unpacking
  assign item.op            = i2cee_pkg::op_e'(s_axis_tuser);
  assign item.start_address = s_axis_tdata[15:0];
  assign item.byte_count    = s_axis_tdata[32:16];
  assign item.write_data    = s_axis_tdata[40:33];
  assign item.bus_status    = s_axis_tdata[48:41];
  assign item.bus_read_data = s_axis_tdata[56:49];

  i2cee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .item_i     (item),
    .q_full_i   (q_full),
    .push_o     (push),
    .desc_o     (desc)
  );

  i2cee_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  i2cee_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cmd_o   (out_cmd),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = out_cmd;

`ifndef SYNTHESIS
  // a shown command that is not the last keeps the rest of its list queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> head.valid)
    else $error("command list left the queue before its last command");

  // a reject is always a single-command transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_cmd == i2cee_pkg::CmdReject |-> m_axis_tlast)
    else $error("reject not marked last");

  // queue never pops while empty and never pushes while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && !head.valid) && !(push && q_full))
    else $error("queue overrun or underrun");

  // after a pop with nothing pushed, a full queue is no longer full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full && pop && !push |=> !q_full)
    else $error("queue fill level did not drop after pop");
`endif

endmodule

// ===== verif/i2c_eeprom_page_access_sequencer_top_tb.sv =====
// testbench for i2c_eeprom_page_access_sequencer_top: directed and random host
// transactions checked against a cycle-free command predictor held in a scoreboard class
// depends on i2cee_pkg and the sequencer rtl under src
`timescale 1ns / 1ps

module i2c_eeprom_page_access_sequencer_top_tb;
  import i2cee_pkg::*;

  localparam int NumSettings = 8;
  localparam int ItemsPerSetting = 60;
  localparam int HoldSetting = 2;
  localparam int HoldCycles = 300;

  // one expected bus command
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
    logic       last;
  } bus_cmd_t;

  // predicts the command stream and checks what the block emits
  class eeprom_cmd_scoreboard;
    bus_cmd_t    expected_cmds[$];
    int          errors;
    int          requests;
    int          checked;
    logic [2:0]  page_log2;
    logic        wide;
    logic [2:0]  pins;
    phase_e      phase;
    logic [15:0] cur_addr;
    logic [16:0] bytes_left;
    logic [7:0]  chunk_left;
    logic [15:0] addr_mask;

    function new();
      errors     = 0;
      requests   = 0;
      checked    = 0;
      page_log2  = 3'd4;
      wide       = 1'b0;
      pins       = 3'd0;
      phase      = PhIdle;
      cur_addr   = '0;
      bytes_left = '0;
      chunk_left = '0;
      addr_mask  = 16'((32'd1 << AddrWidth) - 32'd1);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegPageLog2: page_log2 = value[2:0];
        RegWideAddr: wide = value[0];
        RegDevPins:  pins = value[2:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    function void push_cmd(cmd_e cmd, logic [7:0] data);
      bus_cmd_t e;
      e.cmd  = cmd;
      e.data = data;
      e.last = 1'b0;
      expected_cmds.push_back(e);
    endfunction

    // chip select bits, narrow parts fold in address bits 10..8
    function logic [7:0] control(logic [7:0] base);
      logic [2:0] sel;
      sel = pins;
      if (!wide) sel = sel | cur_addr[10:8];
      return base | {4'b0000, sel, 1'b0};
    endfunction

    // start a page chunk: size limited by the room left in the page
    function void open_chunk();
      logic [2:0]  lg;
      logic [16:0] page;
      logic [16:0] room;
      lg = (page_log2 < MinPageLog2) ? MinPageLog2 : page_log2;
      page = 17'd1 << lg;
      room = page - ({1'b0, cur_addr} & (page - 17'd1));
      chunk_left = (room < bytes_left) ? room[7:0] : bytes_left[7:0];
      push_cmd(CmdStart, 8'h00);
      push_cmd(CmdSend, control(CtrlWrite));
      phase = PhWrAck;
    endfunction

    function void push_address();
      if (wide) push_cmd(CmdSend, cur_addr[15:8]);
      push_cmd(CmdSend, cur_addr[7:0]);
    endfunction

    // last byte of a read is always received with nack
    function void push_recv();
      push_cmd((bytes_left == 17'd1) ? CmdRecvNack : CmdRecvAck, 8'h00);
    endfunction

    // accepted host transaction: queue the commands it causes
    function void note_request(op_e op, logic [15:0] addr, logic [16:0] count,
                               logic [7:0] wdata, logic [7:0] status, logic [7:0] rdata);
      bus_cmd_t tail;
      logic     ack;
      ack = (status & StatusMask) == AckStatus;
      requests++;
      if ((op == OpBeginWr || op == OpBeginRd) && phase == PhIdle && count != 17'd0) begin
        cur_addr   = addr & addr_mask;
        bytes_left = count;
        if (op == OpBeginWr) begin
          open_chunk();
        end else begin
          chunk_left = '0;
          push_cmd(CmdStart, 8'h00);
          push_cmd(CmdSend, control(CtrlWrite));
          phase = PhRdAck;
        end
      end else if (op == OpData && phase == PhWrData) begin
        push_cmd(CmdSend, wdata);
        cur_addr   = (cur_addr + 16'd1) & addr_mask;
        bytes_left = bytes_left - 17'd1;
        chunk_left = chunk_left - 8'd1;
        if (chunk_left == 8'd0 || bytes_left == 17'd0) begin
          push_cmd(CmdStop, 8'h00);
          push_cmd(CmdWait, 8'h00);
          if (bytes_left != 17'd0) open_chunk();
          else phase = PhIdle;
        end
      end else if (op == OpReply && (phase == PhWrAck || phase == PhRdAck)) begin
        if (!ack) begin
          push_cmd(CmdStop, 8'h00);
          if (phase == PhWrAck) push_cmd(CmdWait, 8'h00);
          push_cmd(CmdNoack, 8'h00);
          phase = PhIdle;
        end else if (phase == PhWrAck) begin
          push_address();
          phase = PhWrData;
        end else begin
          push_address();
          push_cmd(CmdStart, 8'h00);
          push_cmd(CmdSend, control(CtrlRead));
          push_recv();
          phase = PhRdData;
        end
      end else if (op == OpReply && phase == PhRdData) begin
        push_cmd(CmdData, rdata);
        cur_addr   = (cur_addr + 16'd1) & addr_mask;
        bytes_left = bytes_left - 17'd1;
        if (bytes_left != 17'd0) begin
          push_recv();
        end else begin
          push_cmd(CmdStop, 8'h00);
          phase = PhIdle;
        end
      end else begin
        push_cmd(CmdReject, 8'h00);
      end
      tail = expected_cmds.pop_back();
      tail.last = 1'b1;
      expected_cmds.push_back(tail);
    endfunction

    // accepted output transaction against the oldest expectation
    function void check_command(logic [3:0] cmd, logic [7:0] data, logic last);
      bus_cmd_t e;
      if (expected_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected command, expected none, actual cmd=%0d byte=%02h last=%0b",
                 $time, cmd, data, last);
        return;
      end
      e = expected_cmds.pop_front();
      checked++;
      if (cmd !== e.cmd) begin
        errors++;
        $display("%0t: cmd mismatch, expected %0d, actual %0d", $time, e.cmd, cmd);
      end
      if (data !== e.data) begin
        errors++;
        $display("%0t: cmd_byte mismatch, expected %02h, actual %02h", $time, e.data, data);
      end
      if (last !== e.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, e.last, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  eeprom_cmd_scoreboard sb = new();

  bit src_burst = 1'b0;
  bit snk_burst = 1'b0;
  int sink_hold = 0;

  i2c_eeprom_page_access_sequencer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_command(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  // receiver: random stall per command, or one long hold when asked
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = snk_burst ? 0 : $urandom_range(0, 10);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one host transaction; valid stays up afterwards until the next call or src_stop
  task automatic send_item(op_e op, logic [15:0] addr, logic [16:0] count,
                           logic [7:0] wdata, logic [7:0] status, logic [7:0] rdata);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, rdata, status, wdata, count, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, addr, count, wdata, status, rdata);
  endtask

  task automatic src_stop();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // setup and access cycle, then update the predictor copy
  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // next item: mostly what the current phase expects, some noise;
  // closing mode ends transfers quickly by refusing acks
  task automatic pick_item(bit closing, output op_e op, output logic [15:0] addr,
                           output logic [16:0] count, output logic [7:0] wdata,
                           output logic [7:0] status, output logic [7:0] rdata);
    int  roll;
    bit  nack;
    addr  = 16'($urandom);
    wdata = 8'($urandom);
    rdata = 8'($urandom);
    status = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 70)      count = 17'($urandom_range(1, 24));
    else if (roll < 88) count = 17'($urandom_range(25, 200));
    else                count = 17'($urandom_range(201, 65536));
    if (!closing && $urandom_range(0, 99) < 8) begin
      op = op_e'($urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0) count = 17'd0;
    end else begin
      case (sb.phase)
        PhIdle: op = $urandom_range(0, 1) ? OpBeginWr : OpBeginRd;
        PhWrAck, PhRdAck: begin
          op = OpReply;
          // long transfers are aborted so the run stays short
          nack = closing || sb.bytes_left > 17'd200 || $urandom_range(0, 9) == 0;
          if (nack) begin
            while ((status & StatusMask) == AckStatus) status = 8'($urandom);
          end else begin
            status = AckStatus | 8'($urandom_range(0, 7));
          end
        end
        PhWrData: op = OpData;
        default:  op = OpReply;
      endcase
    end
  endtask

  task automatic drain_to_idle();
    op_e         op;
    logic [15:0] a;
    logic [16:0] c;
    logic [7:0]  w;
    logic [7:0]  s;
    logic [7:0]  r;
    while (sb.phase != PhIdle) begin
      pick_item(1'b1, op, a, c, w, s, r);
      send_item(op, a, c, w, s, r);
    end
  endtask

  initial begin
    int          k;
    int          n;
    int          set_log2[6];
    int          set_wide[6];
    int          set_pins[6];
    op_e         op;
    logic [15:0] a;
    logic [16:0] c;
    logic [7:0]  w;
    logic [7:0]  s;
    logic [7:0]  r;
    set_log2 = '{3, 7, 0, 2, 5, 4};
    set_wide = '{1, 0, 1, 0, 1, 0};
    set_pins = '{7, 5, 0, 3, 2, 7};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpBeginWr;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part under reset defaults
    // zero count and ops that are wrong while idle
    send_item(OpBeginWr, 16'h1234, 17'd0, 8'h00, 8'h00, 8'h00);
    send_item(OpData,    16'h0000, 17'd1, 8'hFF, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h18, 8'hFF);
    // write across a page boundary and the address wrap
    send_item(OpBeginWr, 16'hFFFE, 17'd4, 8'h00, 8'h00, 8'h00);
    send_item(OpData,    16'h0000, 17'd1, 8'h11, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h1F, 8'h00);
    send_item(OpBeginRd, 16'h0100, 17'd2, 8'h00, 8'h00, 8'h00);
    send_item(OpData,    16'h0000, 17'd1, 8'h00, 8'h00, 8'h00);
    send_item(OpData,    16'h0000, 17'd1, 8'hFF, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h18, 8'h00);
    send_item(OpData,    16'h0000, 17'd1, 8'hA5, 8'h00, 8'h00);
    send_item(OpData,    16'h0000, 17'd1, 8'h5A, 8'h00, 8'h00);
    // largest count, refused by the device
    send_item(OpBeginWr, 16'h1234, 17'd65536, 8'h00, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h20, 8'h00);
    // read with narrow high address bits, begin while busy
    send_item(OpBeginRd, 16'h07FF, 17'd3, 8'h00, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h18, 8'h00);
    send_item(OpBeginWr, 16'h0000, 17'd1, 8'h00, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h00, 8'hFF);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h00, 8'h81);
    // single byte read: first receive is the nack form
    send_item(OpBeginRd, 16'h0000, 17'd1, 8'h00, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h1C, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h00, 8'h3C);
    // read refused
    send_item(OpBeginRd, 16'hFFFF, 17'd2, 8'h00, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'hFF, 8'h00);
    // single byte write at the top address
    send_item(OpBeginWr, 16'hFFFF, 17'd1, 8'h00, 8'h00, 8'h00);
    send_item(OpReply,   16'h0000, 17'd1, 8'h00, 8'h18, 8'h00);
    send_item(OpData,    16'h0000, 17'd1, 8'hC3, 8'h00, 8'h00);

    // random part, one block per register setting
    for (k = 0; k < NumSettings; k++) begin
      drain_to_idle();
      src_stop();
      wait_results();
      if (k < 6) begin
        apb_write(RegPageLog2, 32'(set_log2[k]));
        apb_write(RegWideAddr, 32'(set_wide[k]));
        apb_write(RegDevPins, 32'(set_pins[k]));
      end else begin
        apb_write(RegPageLog2, 32'($urandom_range(0, 7)));
        apb_write(RegWideAddr, 32'($urandom_range(0, 1)));
        apb_write(RegDevPins, 32'($urandom_range(0, 7)));
      end
      // back-to-back input against a held output
      if (k == HoldSetting) begin
        src_burst = 1'b1;
        sink_hold = HoldCycles;
      end
      for (n = 0; n < ItemsPerSetting; n++) begin
        if ((k != HoldSetting || n > 40) && $urandom_range(0, 24) == 0)
          src_burst = ~src_burst;
        if ($urandom_range(0, 24) == 0) snk_burst = ~snk_burst;
        pick_item(1'b0, op, a, c, w, s, r);
        send_item(op, a, c, w, s, r);
      end
    end

    drain_to_idle();
    src_stop();
    wait_results();
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d expected commands never arrived", $time, sb.pending());
    end
    $display("run covered %0d host transactions and %0d bus commands over %0d register settings",
             sb.requests, sb.checked, NumSettings + 1);
    $display("with page splits, aborted transfers, rejects, a long output hold, %0d errors",
             sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
